FILE: rtl/dcdm_pkg.sv
// ----------------------------------------------------------------------------
// dcdm_pkg: shared types and constants of the debounced counter display mux
// op codes, display phases, select codes and the seven-segment table
// ----------------------------------------------------------------------------
package dcdm_pkg;

  localparam int unsigned CountWidth  = 8;
  localparam int unsigned SampleWidth = 8;
  localparam int unsigned SegWidth    = 8;
  localparam int unsigned SelWidth    = 3;
  localparam int unsigned OpWidth     = 2;

  localparam logic [CountWidth-1:0] LockoutReset = 8'd200;
  localparam logic [3:0]            NibbleMask   = 4'hF;

  typedef enum logic [OpWidth-1:0] {
    OP_TICK   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_UNITS    = 2'd0,
    PH_TENS     = 2'd1,
    PH_COUNTER  = 2'd2,
    PH_RESERVED = 2'd3
  } phase_t;

  localparam logic [SelWidth-1:0] SelNone    = 3'b000;
  localparam logic [SelWidth-1:0] SelUnits   = 3'b001;
  localparam logic [SelWidth-1:0] SelTens    = 3'b010;
  localparam logic [SelWidth-1:0] SelCounter = 3'b100;

  // hex digit to segment pattern, bit0 = segment a
  function automatic logic [SegWidth-1:0] seg_decode(input logic [3:0] nibble);
    logic [SegWidth-1:0] pattern;
    unique case (nibble & NibbleMask)
      4'h0: pattern = 8'h3F;
      4'h1: pattern = 8'h06;
      4'h2: pattern = 8'h5B;
      4'h3: pattern = 8'h4F;
      4'h4: pattern = 8'h66;
      4'h5: pattern = 8'h6D;
      4'h6: pattern = 8'h7D;
      4'h7: pattern = 8'h07;
      4'h8: pattern = 8'h7F;
      4'h9: pattern = 8'h6F;
      4'hA: pattern = 8'h77;
      4'hB: pattern = 8'h7C;
      4'hC: pattern = 8'h39;
      4'hD: pattern = 8'h5E;
      4'hE: pattern = 8'h79;
      default: pattern = 8'h71;
    endcase
    return pattern;
  endfunction

endpackage

FILE: rtl/dcdm_if.sv
// ----------------------------------------------------------------------------
// dcdm_if: valid/ready channels of the debounced counter display mux
// item channel, result channel and setup write channel
// ----------------------------------------------------------------------------
interface dcdm_item_if;
  logic                                   valid;
  logic                                   ready;
  logic [dcdm_pkg::OpWidth-1:0]           op;
  logic                                   button_up_n;
  logic                                   button_down_n;
  logic [dcdm_pkg::SampleWidth-1:0]       sample_value;

  modport source (output valid, op, button_up_n, button_down_n, sample_value,
                  input ready);
  modport sink   (input valid, op, button_up_n, button_down_n, sample_value,
                  output ready);
endinterface

interface dcdm_result_if;
  logic                                   valid;
  logic                                   ready;
  logic [dcdm_pkg::SegWidth-1:0]          segments;
  logic [dcdm_pkg::SelWidth-1:0]          digit_select;
  logic                                   alarm;
  logic [dcdm_pkg::CountWidth-1:0]        count_value;

  modport source (output valid, segments, digit_select, alarm, count_value,
                  input ready);
  modport sink   (input valid, segments, digit_select, alarm, count_value,
                  output ready);
endinterface

interface dcdm_setup_if;
  logic                                   valid;
  logic                                   ready;
  logic [dcdm_pkg::CountWidth-1:0]        data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/debounced_counter_display_mux.sv
// a result word is held in the result register from the cycle after its item word is accepted
// throughput: one item word per cycle while the result port is ready, set by the single state update at acceptance
// items are taken while a result waits, as long as the result is taken in the same cycle
// reset (rst, synchronous, active high): counter, lockouts, phase and outputs go to zero,
// lockout_ticks goes to 200, the result register goes empty
// ----------------------------------------------------------------------------
// debounced_counter_display_mux
// up/down counter with button lockout, three-phase display rotation and
// sample-above-counter alarm, one result word for every item word
// ----------------------------------------------------------------------------
module debounced_counter_display_mux (
  input  logic                 clk,
  input  logic                 rst,
  dcdm_item_if.sink            items,
  dcdm_result_if.source        results,
  dcdm_setup_if.sink           setup
);

  // state registers
  logic [dcdm_pkg::CountWidth-1:0]  lockout_ticks;
  logic [dcdm_pkg::CountWidth-1:0]  count;
  logic [dcdm_pkg::SampleWidth-1:0] sample_hold;
  logic [dcdm_pkg::CountWidth-1:0]  up_lockout;
  logic [dcdm_pkg::CountWidth-1:0]  down_lockout;
  dcdm_pkg::phase_t                 phase;
  logic [dcdm_pkg::SegWidth-1:0]    segment_reg;
  logic [dcdm_pkg::SelWidth-1:0]    select_reg;
  logic                             alarm_reg;

  // next values
  logic [dcdm_pkg::CountWidth-1:0]  count_next;
  logic [dcdm_pkg::SampleWidth-1:0] sample_hold_next;
  logic [dcdm_pkg::CountWidth-1:0]  up_lockout_next;
  logic [dcdm_pkg::CountWidth-1:0]  down_lockout_next;
  dcdm_pkg::phase_t                 phase_next;
  logic [dcdm_pkg::SegWidth-1:0]    segment_next;
  logic [dcdm_pkg::SelWidth-1:0]    select_next;
  logic                             alarm_next;
  logic [dcdm_pkg::CountWidth-1:0]  count_up;

  // result register
  logic                             out_valid;
  logic                             item_accept;
  dcdm_pkg::op_t                    op;

  // setup port never stalls; the user must write only while idle, the block does not enforce it
  assign setup.ready = 1'b1;

  // take a new word whenever the result register is empty or being drained
  assign items.ready = !out_valid || results.ready;
  assign item_accept = items.valid && items.ready;
  assign op          = dcdm_pkg::op_t'(items.op);

  always_comb begin
    count_next        = count;
    sample_hold_next  = sample_hold;
    up_lockout_next   = up_lockout;
    down_lockout_next = down_lockout;
    phase_next        = phase;
    segment_next      = segment_reg;
    select_next       = select_reg;
    alarm_next        = alarm_reg;
    count_up          = count;

    unique case (op)
      dcdm_pkg::OP_TICK: begin
        // lockouts count down in the same step as the display moves on
        if (up_lockout != '0) begin
          up_lockout_next = up_lockout - 1'b1;
        end
        if (down_lockout != '0) begin
          down_lockout_next = down_lockout - 1'b1;
        end
        unique case (phase)
          dcdm_pkg::PH_UNITS: begin
            segment_next = dcdm_pkg::seg_decode(sample_hold[3:0]);
            select_next  = dcdm_pkg::SelUnits;
            phase_next   = dcdm_pkg::PH_TENS;
          end
          dcdm_pkg::PH_TENS: begin
            segment_next = dcdm_pkg::seg_decode(sample_hold[7:4]);
            select_next  = dcdm_pkg::SelTens;
            phase_next   = dcdm_pkg::PH_COUNTER;
          end
          dcdm_pkg::PH_COUNTER: begin
            segment_next = count;
            select_next  = dcdm_pkg::SelCounter;
            phase_next   = dcdm_pkg::PH_UNITS;
          end
          default: begin
            // unreachable phase: blank the select, keep segments
            select_next = dcdm_pkg::SelNone;
            phase_next  = dcdm_pkg::PH_UNITS;
          end
        endcase
        alarm_next = sample_hold > count;
      end
      dcdm_pkg::OP_BUTTON: begin
        // up acts first, down then works on the result
        if (!items.button_up_n && up_lockout == '0) begin
          count_up        = count + 1'b1;
          up_lockout_next = lockout_ticks;
        end
        count_next = count_up;
        if (!items.button_down_n && down_lockout == '0) begin
          count_next        = count_up - 1'b1;
          down_lockout_next = lockout_ticks;
        end
      end
      dcdm_pkg::OP_SAMPLE: begin
        sample_hold_next = items.sample_value;
      end
      default: begin
        // unused op: state stays, current outputs are reported
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks <= dcdm_pkg::LockoutReset;
      count         <= '0;
      sample_hold   <= '0;
      up_lockout    <= '0;
      down_lockout  <= '0;
      phase         <= dcdm_pkg::PH_UNITS;
      segment_reg   <= '0;
      select_reg    <= dcdm_pkg::SelNone;
      alarm_reg     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (setup.valid && setup.ready) begin
        lockout_ticks <= setup.data;
      end
      if (item_accept) begin
        count        <= count_next;
        sample_hold  <= sample_hold_next;
        up_lockout   <= up_lockout_next;
        down_lockout <= down_lockout_next;
        phase        <= phase_next;
        segment_reg  <= segment_next;
        select_reg   <= select_next;
        alarm_reg    <= alarm_next;
        out_valid    <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the result word is the state right after the step
  assign results.valid        = out_valid;
  assign results.segments     = segment_reg;
  assign results.digit_select = select_reg;
  assign results.alarm        = alarm_reg;
  assign results.count_value  = count;

`ifndef SYNTHESIS
  // rotation never lands in the unused phase
  assert property (@(posedge clk) disable iff (rst) phase != dcdm_pkg::PH_RESERVED)
    else $error("display phase reached unused code");

  // at most one digit driven at a time
  assert property (@(posedge clk) disable iff (rst) $onehot0(select_reg))
    else $error("digit select not one-hot");

  // counter moves only on an accepted button word
  assert property (@(posedge clk) disable iff (rst)
    !(item_accept && op == dcdm_pkg::OP_BUTTON) |=> $stable(count))
    else $error("counter changed without a button word");

  // every accepted word leaves a result pending
  assert property (@(posedge clk) disable iff (rst) item_accept |=> out_valid)
    else $error("accepted word produced no result");
`endif

endmodule
